// ----- rtl/sfm_pkg.sv -----
// ---------------------------------------------------------------------------
// sfm_pkg: shared types and constants for the supply fault monitor
// Threshold set, monitor state, mode codes and the leaky integrator step.
// ---------------------------------------------------------------------------
`default_nettype none

package sfm_pkg;

   localparam int unsigned VOLT_W    = 10;
   localparam int unsigned CURR_W    = 14;
   localparam int unsigned COUNT_W   = 11;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned MASK_W    = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 14;

   // Alarm mode codes
   localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VOLT    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CURRENT = 2'd2;

   // LED blink masks
   localparam logic [MASK_W-1:0] MASK_NONE  = 3'd0;
   localparam logic [MASK_W-1:0] MASK_OVER  = 3'd2;
   localparam logic [MASK_W-1:0] MASK_UNDER = 3'd4;
   localparam logic [MASK_W-1:0] MASK_ALL   = 3'd7;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY_VAL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_CLASS   = 3'd4;

   // Integrator and trip constants
   localparam logic [COUNT_W-1:0] INTEG_CAP  = 11'd1000;
   localparam logic [COUNT_W-1:0] INTEG_UP   = 11'd20;
   localparam logic [COUNT_W-1:0] INTEG_DOWN = 11'd5;
   localparam logic [COUNT_W-1:0] VOLT_TRIP  = 11'd100;
   localparam logic [COUNT_W-1:0] AMP_TRIP   = 11'd70;
   localparam logic [COUNT_W-1:0] AMP_SEVERE = 11'd750;
   localparam logic [COUNT_W-1:0] AMP_FORCED = 11'd2000;
   localparam logic [COUNT_W-1:0] AMP_CLEAR  = 11'd10;

   typedef struct packed {
      logic [VOLT_W-1:0] volt_low;
      logic [VOLT_W-1:0] volt_high;
      logic [CURR_W-1:0] current_max;
      logic              supply_valid;
      logic              supply_is_low_class;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] under_volt_count;
      logic [COUNT_W-1:0] over_volt_count;
      logic [COUNT_W-1:0] over_current_count;
      logic [MODE_W-1:0]  alarm_mode;
      logic               heater_latch;
      logic [MASK_W-1:0]  led_mask;
   } mon_state_type;

   // One leaky integrator step: climb while below the cap, decay above the floor.
   function automatic logic [COUNT_W-1:0] leak(input logic [COUNT_W-1:0] c,
                                               input logic cond);
      logic [COUNT_W-1:0] r;
      r = c;
      if (cond) begin
         if (c < INTEG_CAP) r = c + INTEG_UP;
      end else begin
         if (c > INTEG_DOWN) r = c - INTEG_DOWN;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sfm_step.sv -----
// ---------------------------------------------------------------------------
// sfm_step: one monitor tick
// Next integrator counts, alarm mode, blink mask and heater latch for a sample.
// ---------------------------------------------------------------------------
`default_nettype none

module sfm_step import sfm_pkg::*; (
   input  wire cfg_type            cfg,
   input  wire mon_state_type      cur,
   input  wire logic [VOLT_W-1:0]  volt_sample,
   input  wire logic [CURR_W-1:0]  current_sample,
   output mon_state_type           nxt,
   output logic                    restore_display
);

   logic restored;
   logic under_cond;
   logic over_cond;
   logic amp_cond;

   assign under_cond = cfg.supply_valid && (volt_sample <= cfg.volt_low);
   assign over_cond  = cfg.supply_valid && (volt_sample >= cfg.volt_high);
   assign amp_cond   = cfg.supply_valid && (current_sample > cfg.current_max);

   always_comb begin
      nxt      = cur;
      restored = 1'b0;

      // Voltage section runs only outside a current alarm
      if ((cur.alarm_mode == MODE_NORMAL) || (cur.alarm_mode == MODE_VOLT)) begin
         nxt.under_volt_count = leak(cur.under_volt_count, under_cond);
         nxt.over_volt_count  = leak(cur.over_volt_count, over_cond);
         if (nxt.over_volt_count > VOLT_TRIP) begin
            nxt.alarm_mode = MODE_VOLT;
            nxt.led_mask   = MASK_OVER;
         end else if (nxt.under_volt_count > VOLT_TRIP) begin
            nxt.alarm_mode = MODE_VOLT;
            nxt.led_mask   = MASK_UNDER;
            if (cfg.supply_is_low_class) nxt.heater_latch = 1'b1;
         end else if (cur.alarm_mode == MODE_VOLT) begin
            nxt.alarm_mode = MODE_NORMAL;
            nxt.led_mask   = MASK_NONE;
            restored       = 1'b1;
            if (cfg.supply_is_low_class) nxt.heater_latch = 1'b0;
         end
      end

      // Current section
      nxt.over_current_count = leak(cur.over_current_count, amp_cond);
      if ((nxt.over_current_count >= AMP_TRIP) && (nxt.over_current_count < AMP_SEVERE)) begin
         nxt.alarm_mode = MODE_CURRENT;
         nxt.led_mask   = MASK_ALL;
      end else if ((nxt.over_current_count >= AMP_SEVERE) && !nxt.heater_latch) begin
         nxt.over_current_count = AMP_FORCED;
         nxt.heater_latch       = 1'b1;
      end else if ((nxt.over_current_count < AMP_CLEAR) &&
                   (nxt.alarm_mode == MODE_CURRENT)) begin
         nxt.alarm_mode   = MODE_NORMAL;
         nxt.led_mask     = MASK_NONE;
         nxt.heater_latch = 1'b0;
         restored         = 1'b1;
      end
   end

   assign restore_display = restored && (nxt.alarm_mode == MODE_NORMAL);

endmodule

`default_nettype wire

// ----- rtl/supply_fault_monitor.sv -----
// An accepted request transaction is held in the input register, then the tick's
// compare/add logic loads its response into the result register.
// Throughput: one transaction per cycle while rsp_stall is low; the tick logic on
// the three 11-bit counters is combinational, so samples wait only on rsp_stall.
// Reset (synchronous, active high): counters zero, mode normal, latch and mask
// clear, thresholds to volt_low 0, volt_high 1023, current_max 16383, supply invalid.
// ---------------------------------------------------------------------------
// supply_fault_monitor: supply and heater fault monitor
// Leaky integrators on under-voltage, over-voltage and over-current drive the
// alarm mode, LED blink mask and heater-disable latch, one response per sample.
// ---------------------------------------------------------------------------
`default_nettype none

module supply_fault_monitor import sfm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [VOLT_W-1:0]     req_volt_sample,
   input  wire logic [CURR_W-1:0]     req_current_sample,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [MODE_W-1:0]          rsp_mode,
   output logic [MASK_W-1:0]          rsp_blink_mask,
   output logic                       rsp_restore_display,
   output logic                       rsp_heater_off,
   // configuration write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DAT_W-1:0]  csr_wdata
);

   // Configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Input register
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [VOLT_W-1:0] s1_volt_ff;
   logic [CURR_W-1:0] s1_curr_ff;

   // Monitor state
   mon_state_type st_ff;
   mon_state_type st_next;
   logic          restore_next;

   // Result register
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [MODE_W-1:0] out_mode_ff;
   logic [MASK_W-1:0] out_mask_ff;
   logic              out_restore_ff;
   logic              out_heater_ff;

   logic out_load;   // result register takes a new response
   logic s1_load;    // input register takes a new request

   // The result register is free when empty or when its response leaves now.
   assign out_load  = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   // Hold the input only when it is full and cannot move on.
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign s1_load   = req_valid && !req_stall;

   // Register writes are always accepted; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VOLT_LOW:    cfg_in.volt_low            = csr_wdata[VOLT_W-1:0];
            CSR_VOLT_HIGH:   cfg_in.volt_high           = csr_wdata[VOLT_W-1:0];
            CSR_CURRENT_MAX: cfg_in.current_max         = csr_wdata[CURR_W-1:0];
            CSR_SUPPLY_VAL:  cfg_in.supply_valid        = csr_wdata[0];
            CSR_LOW_CLASS:   cfg_in.supply_is_low_class = csr_wdata[0];
            default:         cfg_in                     = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volt_low            <= '0;
         cfg_ff.volt_high           <= '1;
         cfg_ff.current_max         <= '1;
         cfg_ff.supply_valid        <= 1'b0;
         cfg_ff.supply_is_low_class <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input stage: advance on a new request, drain when its item moves on.
   assign s1_valid_in = s1_load ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_volt_ff <= req_volt_sample;
         s1_curr_ff <= req_current_sample;
      end
   end

   // One monitor tick on the registered sample
   sfm_step u_step (
      .cfg             (cfg_ff),
      .cur             (st_ff),
      .volt_sample     (s1_volt_ff),
      .current_sample  (s1_curr_ff),
      .nxt             (st_next),
      .restore_display (restore_next)
   );

   // Commit the tick to the state together with its response.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.under_volt_count   <= '0;
         st_ff.over_volt_count    <= '0;
         st_ff.over_current_count <= '0;
         st_ff.alarm_mode         <= MODE_NORMAL;
         st_ff.heater_latch       <= 1'b0;
         st_ff.led_mask           <= MASK_NONE;
      end else if (out_load) begin
         st_ff <= st_next;
      end
   end

   // Result register: fill on a tick, empty when the consumer takes it.
   assign out_valid_in = out_load ? 1'b1 : ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_mode_ff    <= st_next.alarm_mode;
         out_mask_ff    <= st_next.led_mask;
         out_restore_ff <= restore_next;
         out_heater_ff  <= st_next.heater_latch;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_mode            = out_mode_ff;
   assign rsp_blink_mask      = out_mask_ff;
   assign rsp_restore_display = out_restore_ff;
   assign rsp_heater_off      = out_heater_ff;

   // Normal mode leaves the LEDs to the level display.
   a_normal_mask : assert property (@(posedge clock) disable iff (reset)
      (st_ff.alarm_mode == MODE_NORMAL) |-> (st_ff.led_mask == MASK_NONE))
      else $error("led mask set while in normal mode");

   // A current alarm always blinks all three LEDs.
   a_current_mask : assert property (@(posedge clock) disable iff (reset)
      (st_ff.alarm_mode == MODE_CURRENT) |-> (st_ff.led_mask == MASK_ALL))
      else $error("current alarm without full blink mask");

   // A restore is only reported when the response ends in normal mode.
   a_restore_normal : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_restore_display) |-> (rsp_mode == MODE_NORMAL))
      else $error("restore_display outside normal mode");

   // A tick that commits must also fill the result register.
   a_commit_out : assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_valid_ff)
      else $error("state committed without a response");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the supply fault monitor
// A fault ledger mirrors the three leaky integrators, the alarm mode, the LED
// mask and the heater latch, and predicts one response per accepted sample.
// Directed samples hit field extremes, threshold edges and an alarm hand-over;
// random bursts of well-formed fault episodes with noise cover the rest under
// six threshold settings, with random idling on both channels in all but one.
// ---------------------------------------------------------------------------

module tb;
   import sfm_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 200000;

   // Voltage bands used to place a sample relative to the active thresholds
   localparam int unsigned BAND_LOW  = 0;
   localparam int unsigned BAND_HIGH = 1;
   localparam int unsigned BAND_MID  = 2;
   localparam int unsigned BAND_ANY  = 3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [MASK_W-1:0] blink_mask;
      logic              restore_display;
      logic              heater_off;
   } tick_out_type;

   // -------------------------------------------------------------------------
   // Fault ledger: shadow copy of thresholds and monitor state, plus the queue
   // of responses still owed by the block.
   // -------------------------------------------------------------------------
   class fault_ledger;
      cfg_type            cfg;
      logic [COUNT_W-1:0] under_cnt, over_cnt, amp_cnt;
      logic [MODE_W-1:0]  mode;
      logic               latch;
      logic [MASK_W-1:0]  mask;
      tick_out_type       owed[$];
      int unsigned        errors, samples, checked;
      int unsigned        severe_trips, restores, volt_ticks, amp_ticks;

      function new();
         cfg.volt_low            = '0;
         cfg.volt_high           = '1;
         cfg.current_max         = '1;
         cfg.supply_valid        = 1'b0;
         cfg.supply_is_low_class = 1'b0;
         under_cnt = '0;
         over_cnt  = '0;
         amp_cnt   = '0;
         mode      = MODE_NORMAL;
         latch     = 1'b0;
         mask      = MASK_NONE;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_VOLT_LOW:    cfg.volt_low            = data[VOLT_W-1:0];
            CSR_VOLT_HIGH:   cfg.volt_high           = data[VOLT_W-1:0];
            CSR_CURRENT_MAX: cfg.current_max         = data[CURR_W-1:0];
            CSR_SUPPLY_VAL:  cfg.supply_valid        = data[0];
            CSR_LOW_CLASS:   cfg.supply_is_low_class = data[0];
            default: ;
         endcase
      endfunction

      // climb by the step while under the cap, otherwise bleed off above the floor
      function logic [COUNT_W-1:0] integrate(logic [COUNT_W-1:0] c, logic hold);
         if (hold) return (c < INTEG_CAP) ? c + INTEG_UP : c;
         return (c > INTEG_DOWN) ? c - INTEG_DOWN : c;
      endfunction

      function void note_sample(logic [VOLT_W-1:0] v, logic [CURR_W-1:0] amps);
         tick_out_type t;
         logic         back_home;
         back_home = 1'b0;
         samples++;
         // voltage section is frozen during a current alarm
         if (mode == MODE_NORMAL || mode == MODE_VOLT) begin
            under_cnt = integrate(under_cnt, cfg.supply_valid && v <= cfg.volt_low);
            over_cnt  = integrate(over_cnt, cfg.supply_valid && v >= cfg.volt_high);
            if (over_cnt > VOLT_TRIP) begin
               mode = MODE_VOLT;
               mask = MASK_OVER;
            end else if (under_cnt > VOLT_TRIP) begin
               mode = MODE_VOLT;
               mask = MASK_UNDER;
               if (cfg.supply_is_low_class) latch = 1'b1;
            end else if (mode == MODE_VOLT) begin
               mode      = MODE_NORMAL;
               mask      = MASK_NONE;
               back_home = 1'b1;
               if (cfg.supply_is_low_class) latch = 1'b0;
            end
         end
         amp_cnt = integrate(amp_cnt, cfg.supply_valid && amps > cfg.current_max);
         if (amp_cnt >= AMP_TRIP && amp_cnt < AMP_SEVERE) begin
            mode = MODE_CURRENT;
            mask = MASK_ALL;
         end else if (amp_cnt >= AMP_SEVERE && !latch) begin
            amp_cnt = AMP_FORCED;
            latch   = 1'b1;
            severe_trips++;
         end else if (amp_cnt < AMP_CLEAR && mode == MODE_CURRENT) begin
            mode      = MODE_NORMAL;
            mask      = MASK_NONE;
            back_home = 1'b1;
            latch     = 1'b0;
         end
         t.mode            = mode;
         t.blink_mask      = mask;
         t.restore_display = back_home && (mode == MODE_NORMAL);
         t.heater_off      = latch;
         if (t.restore_display) restores++;
         if (mode == MODE_VOLT) volt_ticks++;
         if (mode == MODE_CURRENT) amp_ticks++;
         owed.push_back(t);
      endfunction

      function void check_result(logic [MODE_W-1:0] m, logic [MASK_W-1:0] k,
                                 logic r, logic h);
         tick_out_type want;
         if (owed.size() == 0) begin
            $error("response with none outstanding: mode %0d mask %0d", m, k);
            errors++;
            return;
         end
         want = owed.pop_front();
         checked++;
         if (m !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, m);
            errors++;
         end
         if (k !== want.blink_mask) begin
            $error("blink_mask: expected %0d, got %0d", want.blink_mask, k);
            errors++;
         end
         if (r !== want.restore_display) begin
            $error("restore_display: expected %0d, got %0d", want.restore_display, r);
            errors++;
         end
         if (h !== want.heater_off) begin
            $error("heater_off: expected %0d, got %0d", want.heater_off, h);
            errors++;
         end
      endfunction

      function int unsigned pending_count();
         return owed.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block hookup
   // -------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [VOLT_W-1:0]    req_volt_sample = '0;
   logic [CURR_W-1:0]    req_current_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [MODE_W-1:0]    rsp_mode;
   logic [MASK_W-1:0]    rsp_blink_mask;
   logic                 rsp_restore_display;
   logic                 rsp_heater_off;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   fault_ledger ledger = new();
   bit          src_gaps = 1'b1;    // sender inserts random idle cycles
   bit          sink_stalls = 1'b1; // receiver stalls at random
   int unsigned cycle_count = 0;

   supply_fault_monitor dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_volt_sample     (req_volt_sample),
      .req_current_sample  (req_current_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mode            (rsp_mode),
      .rsp_blink_mask      (rsp_blink_mask),
      .rsp_restore_display (rsp_restore_display),
      .rsp_heater_off      (rsp_heater_off),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #4 clock = ~clock;

   // Hard stop in case a handshake never completes
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: decide the stall for the coming edge at each falling edge
   always @(negedge clock) begin
      rsp_stall <= sink_stalls && ($urandom_range(0, 99) < 34);
   end

   // Check every response transaction as it is accepted
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ledger.check_result(rsp_mode, rsp_blink_mask, rsp_restore_display,
                             rsp_heater_off);
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Offer one sample; hold it steady until the block takes it.
   task automatic send_sample(input logic [VOLT_W-1:0] v, input logic [CURR_W-1:0] amps);
      @(negedge clock);
      while (src_gaps && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_volt_sample    <= v;
      req_current_sample <= amps;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.note_sample(v, amps);
   endtask

   // Drop valid and wait for every owed response, then let the pipe empty.
   task automatic settle_all();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DAT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ledger.write_reg(idx, data[CSR_DAT_W-1:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_thresholds(input int unsigned lo, input int unsigned hi,
                                  input int unsigned amax, input bit valid,
                                  input bit low_class);
      write_csr(CSR_VOLT_LOW, lo);
      write_csr(CSR_VOLT_HIGH, hi);
      write_csr(CSR_CURRENT_MAX, amax);
      write_csr(CSR_SUPPLY_VAL, valid);
      write_csr(CSR_LOW_CLASS, low_class);
   endtask

   // Pick a voltage inside a band of the current thresholds
   function automatic logic [VOLT_W-1:0] pick_volt(input int unsigned band);
      int unsigned lo, hi;
      lo = 0;
      hi = 1023;
      case (band)
         BAND_LOW:  hi = ledger.cfg.volt_low;
         BAND_HIGH: lo = ledger.cfg.volt_high;
         BAND_MID: begin
            if (ledger.cfg.volt_high > ledger.cfg.volt_low + 1) begin
               lo = ledger.cfg.volt_low + 1;
               hi = ledger.cfg.volt_high - 1;
            end
         end
         default: ;
      endcase
      return VOLT_W'($urandom_range(hi, lo));
   endfunction

   // Pick a current above or at/below the over-current threshold
   function automatic logic [CURR_W-1:0] pick_amps(input bit over);
      int unsigned lim;
      lim = ledger.cfg.current_max;
      if (!over) return CURR_W'($urandom_range(lim, 0));
      if (lim == 16383) return CURR_W'($urandom_range(16383, 0));
      return CURR_W'($urandom_range(16383, lim + 1));
   endfunction

   // Random fault episodes: mostly clean bursts of one fault, some long quiet
   // stretches to let a forced current count bleed off, and some noise.
   task automatic run_bursts(input int unsigned count);
      int unsigned left, len, roll, k, band, amp_rate;
      bit          mixed;
      left = count;
      while (left > 0) begin
         roll  = $urandom_range(0, 99);
         mixed = 1'b0;
         if (roll < 10) begin
            // noise
            len = $urandom_range(1, 8);  band = BAND_ANY;  amp_rate = 50;
         end else if (roll < 28) begin
            len = $urandom_range(3, 40); band = BAND_HIGH; amp_rate = 0;
         end else if (roll < 46) begin
            len = $urandom_range(3, 40); band = BAND_LOW;  amp_rate = 0;
         end else if (roll < 66) begin
            // long enough at times to reach the severe level
            len = $urandom_range(3, 60); band = BAND_MID;  amp_rate = 100;
         end else if (roll < 84) begin
            len = $urandom_range(10, 200); band = BAND_MID; amp_rate = 0;
         end else begin
            // broken episodes: bands and over-current flicker
            len = $urandom_range(5, 40); band = BAND_ANY;  amp_rate = 50;
            mixed = 1'b1;
         end
         for (k = 0; k < len && left > 0; k++) begin
            if (mixed) band = $urandom_range(BAND_ANY, BAND_LOW);
            send_sample(pick_volt(band), pick_amps($urandom_range(0, 99) < amp_rate));
            left--;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned n;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Invalid supply at reset defaults: extremes only decay, no alarm
      send_sample(10'd0, 14'd0);
      send_sample(10'd1023, 14'd16383);
      send_sample(10'd1023, 14'd0);
      send_sample(10'd0, 14'd16383);
      settle_all();

      // Low-class supply with mid thresholds
      load_thresholds(300, 700, 5000, 1'b1, 1'b1);
      // threshold edges: equal to volt_low is under, equal to current_max is not over
      send_sample(10'd300, 14'd5000);
      send_sample(10'd700, 14'd5001);
      // build an over-voltage alarm
      for (n = 0; n < 6; n++) send_sample(10'd1023, 14'd0);
      // bleed the over-voltage count down toward the trip level
      for (n = 0; n < 4; n++) send_sample(10'd500, 14'd0);
      // voltage alarm ends on the same tick a current alarm starts: no restore
      for (n = 0; n < 4; n++) send_sample(10'd500, 14'd16383);
      // under-voltage while the current alarm freezes the voltage section
      for (n = 0; n < 3; n++) send_sample(10'd0, 14'd0);
      run_bursts(200);
      // hold off the sender until every response is back
      settle_all();
      run_bursts(220);
      settle_all();

      // Extreme thresholds: only exact rails under/over, any nonzero current over
      load_thresholds(0, 1023, 0, 1'b1, 1'b0);
      run_bursts(300);
      settle_all();

      // Crossed thresholds: every sample is both under and over; no idling here
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      load_thresholds(1023, 0, 16383, 1'b1, 1'b0);
      run_bursts(250);
      settle_all();
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;

      // Supply not recognized: all counters bleed off
      load_thresholds($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 16383), 1'b0, 1'b1);
      run_bursts(150);
      settle_all();

      // Random mid thresholds, low-class supply
      load_thresholds($urandom_range(100, 400), $urandom_range(600, 900),
                      $urandom_range(0, 16383), 1'b1, 1'b1);
      run_bursts(330);
      settle_all();

      $display("Covered %0d samples across six threshold settings, %0d responses checked.",
               ledger.samples, ledger.checked);
      $display("Voltage alarm ticks %0d, current alarm ticks %0d, severe trips %0d, restores %0d.",
               ledger.volt_ticks, ledger.amp_ticks, ledger.severe_trips, ledger.restores);
      if (ledger.errors == 0 && ledger.pending_count() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sfm_pkg.sv
rtl/sfm_step.sv
rtl/supply_fault_monitor.sv
tb/tb.sv
